// File: rtl/core/trz_pkg.sv
// ----------------------------------------------------------------------------
// trz_pkg: shared types and constants of the triangle rasterizer
// Sizes of the screen, the stores and the arithmetic datapath, command and
// register codes, and the control structs between the sequencer and its units.
// ----------------------------------------------------------------------------
package trz_pkg;

   localparam int MAX_WIDTH     = 256;
   localparam int MAX_HEIGHT    = 256;
   localparam int SUBPIXEL_BITS = 4;
   localparam int STORE_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);

   localparam int COORD_W  = 8;
   localparam int SIZE_W   = 9;
   localparam int POS_W    = 16;
   localparam int DEPTH_W  = 16;
   localparam int CHAN_W   = 8;
   localparam int COLOUR_W = 3 * CHAN_W;
   localparam int WORD_W   = DEPTH_W + COLOUR_W;
   localparam int COUNT_W  = 17;
   localparam int SLOT_W   = 2;
   localparam int CMD_W    = 2;

   localparam int EDGE_W   = POS_W + 1;
   localparam int CENTRE_W = POS_W + 2;
   localparam int BOX_W    = 13;
   localparam int MUL_A_W  = 36;
   localparam int MUL_B_W  = 18;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int ACC_W    = 56;
   localparam int WEIGHT_W = 36;
   localparam int DEN_W    = 35;
   localparam int DIV_W    = 52;
   localparam int QUOT_W   = 16;
   localparam int DIV_CNT_W = $clog2(QUOT_W + 1);
   localparam int STEP_W   = 3;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;

   localparam int VERTEX_COUNT = 3;
   localparam int HALF_PIXEL   = 1 << (SUBPIXEL_BITS - 1);

   localparam logic [CHAN_W-1:0] RESET_RED   = 8'd30;
   localparam logic [CHAN_W-1:0] RESET_GREEN = 8'd30;
   localparam logic [CHAN_W-1:0] RESET_BLUE  = 8'd40;
   localparam logic [DEPTH_W-1:0] DEPTH_FAR  = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_DRAW  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_CLEAR = 2'd3
   } command_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WIDTH  = 3'd0,
      CSR_HEIGHT = 3'd1,
      CSR_RED    = 3'd2,
      CSR_GREEN  = 3'd3,
      CSR_BLUE   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      MAC_LOAD = 2'd0,
      MAC_ADD  = 2'd1,
      MAC_SUB  = 2'd2
   } mac_op_type;

   typedef struct packed {
      logic                       valid;
      mac_op_type                 op;
      logic signed [MUL_A_W-1:0]  a;
      logic signed [MUL_B_W-1:0]  b;
   } mac_req_type;

   typedef struct packed {
      logic              start;
      logic              wide;
      logic [DIV_W-1:0]  dividend;
      logic [DEN_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [WORD_W-1:0]  wr_data;
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
   } store_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic [DEPTH_W-1:0] depth;
      logic [COUNT_W-1:0] written;
      logic               degen;
   } result_type;

endpackage

// File: rtl/core/trz_if.sv
// ----------------------------------------------------------------------------
// trz_if: channel interfaces of the triangle rasterizer
// Command channel, result channel and register write channel, each with
// valid, ready and payload.
// ----------------------------------------------------------------------------
interface trz_req_if import trz_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        command;
   logic [SLOT_W-1:0]       vertex_slot;
   logic signed [POS_W-1:0] vertex_x;
   logic signed [POS_W-1:0] vertex_y;
   logic [DEPTH_W-1:0]      vertex_depth;
   logic [CHAN_W-1:0]       vertex_red;
   logic [CHAN_W-1:0]       vertex_green;
   logic [CHAN_W-1:0]       vertex_blue;
   logic [COORD_W-1:0]      read_x;
   logic [COORD_W-1:0]      read_y;

   modport source (output valid, command, vertex_slot, vertex_x, vertex_y, vertex_depth,
                   vertex_red, vertex_green, vertex_blue, read_x, read_y,
                   input ready);
   modport sink (input valid, command, vertex_slot, vertex_x, vertex_y, vertex_depth,
                 vertex_red, vertex_green, vertex_blue, read_x, read_y,
                 output ready);
endinterface

interface trz_rsp_if import trz_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CHAN_W-1:0]  pixel_red;
   logic [CHAN_W-1:0]  pixel_green;
   logic [CHAN_W-1:0]  pixel_blue;
   logic [DEPTH_W-1:0] pixel_depth;
   logic [COUNT_W-1:0] pixels_written;
   logic               degenerate;

   modport source (output valid, pixel_red, pixel_green, pixel_blue, pixel_depth,
                   pixels_written, degenerate, input ready);
   modport sink (input valid, pixel_red, pixel_green, pixel_blue, pixel_depth,
                 pixels_written, degenerate, output ready);
endinterface

interface trz_csr_if import trz_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/trz_mac.sv
// ----------------------------------------------------------------------------
// trz_mac: shared multiply-accumulate unit
// Registered product followed by a load, add or subtract into the
// accumulator register; an operation passes the product register first.
// ----------------------------------------------------------------------------
module trz_mac import trz_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  mac_req_type              mac_req,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [PROD_W-1:0] prod_ff;
   logic                     pvalid_ff;
   mac_op_type               pop_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   always_ff @(posedge clock) begin
      prod_ff <= mac_req.a * mac_req.b;
      pop_ff  <= mac_req.op;
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= mac_req.valid;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (pvalid_ff) begin
         case (pop_ff)
            MAC_LOAD: acc_in = ACC_W'(prod_ff);
            MAC_ADD:  acc_in = acc_ff + ACC_W'(prod_ff);
            MAC_SUB:  acc_in = acc_ff - ACC_W'(prod_ff);
            default:  acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// File: rtl/core/trz_div.sv
// ----------------------------------------------------------------------------
// trz_div: iterative restoring divider
// One quotient bit per cycle, 16 or 8 bits; the quotient is known to fit,
// so only that many compare and subtract steps are run.
// ----------------------------------------------------------------------------
module trz_div import trz_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DIV_W-1:0]     rem_ff, dsh_ff;
   logic [QUOT_W-1:0]    quot_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;
   logic                 ge;

   assign ge = rem_ff >= dsh_ff;

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff  <= div_req.dividend;
         dsh_ff  <= DIV_W'(div_req.divisor) << (div_req.wide ? QUOT_W - 1 : CHAN_W - 1);
         quot_ff <= '0;
      end else if (busy_ff) begin
         if (ge) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         dsh_ff  <= dsh_ff >> 1;
         quot_ff <= {quot_ff[QUOT_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= div_req.wide ? DIV_CNT_W'(QUOT_W) : DIV_CNT_W'(CHAN_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

// File: rtl/core/trz_store.sv
// ----------------------------------------------------------------------------
// trz_store: depth and colour store
// One word per pixel holding depth and colour; one write port and one read
// port with registered read data.
// ----------------------------------------------------------------------------
module trz_store import trz_pkg::*; (
   input  logic              clock,
   input  store_req_type     store_req,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [STORE_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rd_data_ff <= mem[store_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/triangle_zbuffer_rasterizer.sv
// ----------------------------------------------------------------------------
// triangle_zbuffer_rasterizer: barycentric triangle rasterizer with z-buffer
// A draw walks every bounding box pixel, interpolates depth for the covered
// ones and colour for those passing the depth test, and writes those.
// One command at a time; the shared multiplier and the bit-serial divider set
// the per-pixel cost. Results wait in an output register.
// Reset runs a clearing pass over the store; no command is taken meanwhile,
// register writes are.
// ----------------------------------------------------------------------------
module triangle_zbuffer_rasterizer import trz_pkg::*; (
   input  logic clock,
   input  logic reset,
   trz_req_if.sink   req_chan,
   trz_rsp_if.source rsp_chan,
   trz_csr_if.sink   csr_chan
);

   typedef enum logic [11:0] {
      S_SWEEP   = 12'b0000_0000_0001,
      S_IDLE    = 12'b0000_0000_0010,
      S_RD_ADDR = 12'b0000_0000_0100,
      S_RD_MEM  = 12'b0000_0000_1000,
      S_RD_DATA = 12'b0000_0001_0000,
      S_DEN     = 12'b0000_0010_0000,
      S_EDGE    = 12'b0000_0100_0000,
      S_WSUM    = 12'b0000_1000_0000,
      S_DIV     = 12'b0001_0000_0000,
      S_WRITE   = 12'b0010_0000_0000,
      S_NEXT    = 12'b0100_0000_0000,
      S_FINISH  = 12'b1000_0000_0000
   } state_type;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                  input logic [SIZE_W-1:0] maxv);
      logic [SIZE_W-1:0] s;
      s = r;
      if (r == '0) s = SIZE_W'(1);
      else if (r > maxv) s = maxv;
      return s;
   endfunction

   function automatic logic signed [BOX_W-1:0] trunc_pix(input logic signed [POS_W-1:0] v);
      logic signed [POS_W:0] ve, mag, sh, rr;
      ve  = (POS_W+1)'(v);
      mag = v[POS_W-1] ? -ve : ve;
      sh  = mag >>> SUBPIXEL_BITS;
      rr  = v[POS_W-1] ? -sh : sh;
      return rr[BOX_W-1:0];
   endfunction

   function automatic logic signed [POS_W-1:0] min3(input logic signed [POS_W-1:0] a,
                                                    input logic signed [POS_W-1:0] b,
                                                    input logic signed [POS_W-1:0] c);
      logic signed [POS_W-1:0] m;
      m = a;
      if (b < m) m = b;
      if (c < m) m = c;
      return m;
   endfunction

   function automatic logic signed [POS_W-1:0] max3(input logic signed [POS_W-1:0] a,
                                                    input logic signed [POS_W-1:0] b,
                                                    input logic signed [POS_W-1:0] c);
      logic signed [POS_W-1:0] m;
      m = a;
      if (b > m) m = b;
      if (c > m) m = c;
      return m;
   endfunction

   state_type state_ff;
   logic [STEP_W-1:0] step_ff;

   // registers
   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [CHAN_W-1:0] clr_r_ff, clr_g_ff, clr_b_ff;
   logic [SIZE_W-1:0] w_eff, h_eff;

   logic signed [POS_W-1:0] vx_ff [VERTEX_COUNT];
   logic signed [POS_W-1:0] vy_ff [VERTEX_COUNT];
   logic [DEPTH_W-1:0]      vz_ff [VERTEX_COUNT];
   logic [COLOUR_W-1:0]     vc_ff [VERTEX_COUNT];

   logic [COORD_W-1:0] rx_ff, ry_ff;
   logic signed [POS_W-1:0]  ax_ff, ay_ff;
   logic signed [EDGE_W-1:0] e1x_ff, e1y_ff, e2x_ff, e2y_ff;
   logic signed [BOX_W-1:0]  bx0_ff, bx1_ff, by0_ff, by1_ff;
   logic signed [WEIGHT_W-1:0] den_ff, nc_ff, wu_ff, wb_ff, wc_ff;
   logic [DEN_W-1:0]   den_abs_ff;
   logic               neg_ff;
   logic [COORD_W-1:0] x_ff, y_ff;
   logic [ADDR_W-1:0]  row_base_ff, addr_ff, sweep_ff;
   logic [1:0]         ch_ff;
   logic [DEPTH_W-1:0] z_ff;
   logic [CHAN_W-1:0]  pr_ff, pg_ff, pb_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COLOUR_W-1:0] sweep_col_ff;
   logic               sweep_cmd_ff;
   result_type         res_ff, rsp_ff;
   logic               rsp_valid_ff;

   // combinational helpers
   logic req_accept;
   logic signed [CENTRE_W-1:0] qx, qy;
   logic signed [WEIGHT_W-1:0] nb, nu, nb_s, nc_s, nu_s;
   logic signed [WEIGHT_W-1:0] den_now;
   logic signed [BOX_W-1:0] tx0, tx1, ty0, ty1, wmax, hmax;
   logic [COORD_W-1:0]  y_sel;
   logic [ADDR_W-1:0]   row_mul;
   logic [WORD_W-1:0]   store_rd;
   logic [DEPTH_W-1:0]  stored_depth;
   logic signed [MUL_B_W-1:0] wsum_val;

   mac_req_type   mac_req;
   logic signed [ACC_W-1:0] acc;
   div_req_type   div_req;
   div_rsp_type   div_rsp;
   store_req_type store_req;

   trz_mac u_mac (.clock(clock), .reset(reset), .mac_req(mac_req), .acc(acc));
   trz_div u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));
   trz_store u_store (.clock(clock), .store_req(store_req), .rd_data(store_rd));

   assign w_eff = eff_size(width_ff, SIZE_W'(MAX_WIDTH));
   assign h_eff = eff_size(height_ff, SIZE_W'(MAX_HEIGHT));

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // pixel centre relative to vertex zero
   assign qx = $signed(CENTRE_W'({x_ff, {SUBPIXEL_BITS{1'b0}}})) + CENTRE_W'(HALF_PIXEL)
             - CENTRE_W'(ax_ff);
   assign qy = $signed(CENTRE_W'({y_ff, {SUBPIXEL_BITS{1'b0}}})) + CENTRE_W'(HALF_PIXEL)
             - CENTRE_W'(ay_ff);

   assign nb     = acc[WEIGHT_W-1:0];
   assign nu     = den_ff - nb - nc_ff;
   assign nb_s   = neg_ff ? -nb : nb;
   assign nc_s   = neg_ff ? -nc_ff : nc_ff;
   assign nu_s   = neg_ff ? -nu : nu;
   assign den_now = acc[WEIGHT_W-1:0];

   assign tx0  = trunc_pix(min3(vx_ff[0], vx_ff[1], vx_ff[2]));
   assign tx1  = trunc_pix(max3(vx_ff[0], vx_ff[1], vx_ff[2]));
   assign ty0  = trunc_pix(min3(vy_ff[0], vy_ff[1], vy_ff[2]));
   assign ty1  = trunc_pix(max3(vy_ff[0], vy_ff[1], vy_ff[2]));
   assign wmax = $signed(BOX_W'(w_eff - SIZE_W'(1)));
   assign hmax = $signed(BOX_W'(h_eff - SIZE_W'(1)));

   assign y_sel   = (state_ff == S_RD_ADDR) ? ry_ff : by0_ff[COORD_W-1:0];
   assign row_mul = ADDR_W'(y_sel * w_eff);

   assign stored_depth = store_rd[WORD_W-1 -: DEPTH_W];

   // vertex attribute for the weighted sum
   always_comb begin
      logic [1:0] vi;
      vi = (step_ff == STEP_W'(0)) ? 2'd0 : (step_ff == STEP_W'(1)) ? 2'd1 : 2'd2;
      case (ch_ff)
         2'd0:    wsum_val = $signed(MUL_B_W'(vz_ff[vi]));
         2'd1:    wsum_val = $signed(MUL_B_W'(vc_ff[vi][3*CHAN_W-1 -: CHAN_W]));
         2'd2:    wsum_val = $signed(MUL_B_W'(vc_ff[vi][2*CHAN_W-1 -: CHAN_W]));
         default: wsum_val = $signed(MUL_B_W'(vc_ff[vi][CHAN_W-1:0]));
      endcase
   end

   // shared multiplier schedule
   always_comb begin
      mac_req = '{valid: 1'b0, op: MAC_LOAD, a: '0, b: '0};
      case (state_ff)
         S_DEN: begin
            if (step_ff == STEP_W'(0)) begin
               mac_req = '{valid: 1'b1, op: MAC_LOAD, a: MUL_A_W'(e2x_ff), b: MUL_B_W'(e1y_ff)};
            end else if (step_ff == STEP_W'(1)) begin
               mac_req = '{valid: 1'b1, op: MAC_SUB, a: MUL_A_W'(e1x_ff), b: MUL_B_W'(e2y_ff)};
            end
         end
         S_EDGE: begin
            case (step_ff)
               STEP_W'(0): mac_req = '{valid: 1'b1, op: MAC_LOAD, a: MUL_A_W'(qx),
                                       b: MUL_B_W'(e1y_ff)};
               STEP_W'(1): mac_req = '{valid: 1'b1, op: MAC_SUB, a: MUL_A_W'(e1x_ff),
                                       b: MUL_B_W'(qy)};
               STEP_W'(2): mac_req = '{valid: 1'b1, op: MAC_LOAD, a: MUL_A_W'(e2x_ff),
                                       b: MUL_B_W'(qy)};
               STEP_W'(3): mac_req = '{valid: 1'b1, op: MAC_SUB, a: MUL_A_W'(qx),
                                       b: MUL_B_W'(e2y_ff)};
               default: ;
            endcase
         end
         S_WSUM: begin
            case (step_ff)
               STEP_W'(0): mac_req = '{valid: 1'b1, op: MAC_LOAD, a: wu_ff, b: wsum_val};
               STEP_W'(1): mac_req = '{valid: 1'b1, op: MAC_ADD, a: wb_ff, b: wsum_val};
               STEP_W'(2): mac_req = '{valid: 1'b1, op: MAC_ADD, a: wc_ff, b: wsum_val};
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      div_req.start    = (state_ff == S_WSUM) && (step_ff == STEP_W'(4));
      div_req.wide     = (ch_ff == 2'd0);
      div_req.dividend = acc[DIV_W-1:0];
      div_req.divisor  = den_abs_ff;
   end

   always_comb begin
      store_req.wr_en   = (state_ff == S_SWEEP) || (state_ff == S_WRITE);
      store_req.wr_addr = (state_ff == S_SWEEP) ? sweep_ff : addr_ff;
      store_req.wr_data = (state_ff == S_SWEEP) ? {DEPTH_FAR, sweep_col_ff}
                                                : {z_ff, pr_ff, pg_ff, pb_ff};
      store_req.rd_en   = (state_ff == S_RD_MEM) || ((state_ff == S_EDGE) &&
                                                     (step_ff == STEP_W'(1)));
      store_req.rd_addr = addr_ff;
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_W'(MAX_WIDTH);
         height_ff <= SIZE_W'(MAX_HEIGHT);
         clr_r_ff  <= RESET_RED;
         clr_g_ff  <= RESET_GREEN;
         clr_b_ff  <= RESET_BLUE;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_WIDTH:  width_ff  <= csr_chan.data;
            CSR_HEIGHT: height_ff <= csr_chan.data;
            CSR_RED:    clr_r_ff  <= csr_chan.data[CHAN_W-1:0];
            CSR_GREEN:  clr_g_ff  <= csr_chan.data[CHAN_W-1:0];
            CSR_BLUE:   clr_b_ff  <= csr_chan.data[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   // vertex registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VERTEX_COUNT; i++) begin
            vx_ff[i] <= '0;
            vy_ff[i] <= '0;
            vz_ff[i] <= '0;
            vc_ff[i] <= '0;
         end
      end else if (req_accept && (req_chan.command == CMD_LOAD) &&
                   (req_chan.vertex_slot < SLOT_W'(VERTEX_COUNT))) begin
         vx_ff[req_chan.vertex_slot] <= req_chan.vertex_x;
         vy_ff[req_chan.vertex_slot] <= req_chan.vertex_y;
         vz_ff[req_chan.vertex_slot] <= req_chan.vertex_depth;
         vc_ff[req_chan.vertex_slot] <= {req_chan.vertex_red, req_chan.vertex_green,
                                         req_chan.vertex_blue};
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         step_ff      <= '0;
         sweep_ff     <= '0;
         sweep_col_ff <= {RESET_RED, RESET_GREEN, RESET_BLUE};
         sweep_cmd_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         step_ff <= step_ff + 1'b1;
         case (state_ff)
            S_SWEEP: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == ADDR_W'(STORE_DEPTH - 1)) begin
                  state_ff <= sweep_cmd_ff ? S_FINISH : S_IDLE;
               end
            end
            S_IDLE: begin
               step_ff <= '0;
               if (req_accept) begin
                  res_ff   <= '0;
                  count_ff <= '0;
                  rx_ff    <= req_chan.read_x;
                  ry_ff    <= req_chan.read_y;
                  case (req_chan.command)
                     CMD_LOAD: state_ff <= S_FINISH;
                     CMD_DRAW: begin
                        ax_ff  <= vx_ff[0];
                        ay_ff  <= vy_ff[0];
                        e1x_ff <= EDGE_W'(vx_ff[1]) - EDGE_W'(vx_ff[0]);
                        e1y_ff <= EDGE_W'(vy_ff[1]) - EDGE_W'(vy_ff[0]);
                        e2x_ff <= EDGE_W'(vx_ff[2]) - EDGE_W'(vx_ff[0]);
                        e2y_ff <= EDGE_W'(vy_ff[2]) - EDGE_W'(vy_ff[0]);
                        bx0_ff <= (tx0 < 0) ? '0 : tx0;
                        bx1_ff <= (tx1 > wmax) ? wmax : tx1;
                        by0_ff <= (ty0 < 0) ? '0 : ty0;
                        by1_ff <= (ty1 > hmax) ? hmax : ty1;
                        state_ff <= S_DEN;
                     end
                     CMD_READ: begin
                        if ((SIZE_W'(req_chan.read_x) < w_eff) &&
                            (SIZE_W'(req_chan.read_y) < h_eff)) begin
                           state_ff <= S_RD_ADDR;
                        end else begin
                           state_ff <= S_FINISH;
                        end
                     end
                     default: begin
                        sweep_ff     <= '0;
                        sweep_col_ff <= {clr_r_ff, clr_g_ff, clr_b_ff};
                        sweep_cmd_ff <= 1'b1;
                        state_ff     <= S_SWEEP;
                     end
                  endcase
               end
            end
            S_RD_ADDR: begin
               addr_ff  <= row_mul + ADDR_W'(rx_ff);
               state_ff <= S_RD_MEM;
            end
            S_RD_MEM: state_ff <= S_RD_DATA;
            S_RD_DATA: begin
               res_ff.red   <= store_rd[3*CHAN_W-1 -: CHAN_W];
               res_ff.green <= store_rd[2*CHAN_W-1 -: CHAN_W];
               res_ff.blue  <= store_rd[CHAN_W-1:0];
               res_ff.depth <= stored_depth;
               state_ff     <= S_FINISH;
            end
            S_DEN: begin
               if (step_ff == STEP_W'(3)) begin
                  den_ff      <= den_now;
                  neg_ff      <= den_now[WEIGHT_W-1];
                  den_abs_ff  <= DEN_W'(den_now[WEIGHT_W-1] ? -den_now : den_now);
                  x_ff        <= bx0_ff[COORD_W-1:0];
                  y_ff        <= by0_ff[COORD_W-1:0];
                  row_base_ff <= row_mul;
                  step_ff     <= '0;
                  if (den_now == '0) begin
                     res_ff.degen <= 1'b1;
                     state_ff     <= S_FINISH;
                  end else if ((bx0_ff > bx1_ff) || (by0_ff > by1_ff)) begin
                     state_ff <= S_FINISH;
                  end else begin
                     state_ff <= S_EDGE;
                  end
               end
            end
            S_EDGE: begin
               if (step_ff == STEP_W'(0)) begin
                  addr_ff <= row_base_ff + ADDR_W'(x_ff);
               end
               if (step_ff == STEP_W'(3)) begin
                  nc_ff <= acc[WEIGHT_W-1:0];
               end
               if (step_ff == STEP_W'(5)) begin
                  wu_ff   <= nu_s;
                  wb_ff   <= nb_s;
                  wc_ff   <= nc_s;
                  ch_ff   <= 2'd0;
                  step_ff <= '0;
                  // edge pixels have a zero weight and count as inside
                  if (nu_s[WEIGHT_W-1] || nb_s[WEIGHT_W-1] || nc_s[WEIGHT_W-1]) begin
                     state_ff <= S_NEXT;
                  end else begin
                     state_ff <= S_WSUM;
                  end
               end
            end
            S_WSUM: begin
               if (step_ff == STEP_W'(4)) begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               step_ff <= '0;
               if (div_rsp.done) begin
                  ch_ff <= ch_ff + 1'b1;
                  case (ch_ff)
                     2'd0: begin
                        z_ff     <= div_rsp.quotient;
                        state_ff <= (div_rsp.quotient >= stored_depth) ? S_NEXT : S_WSUM;
                     end
                     2'd1: begin
                        pr_ff    <= div_rsp.quotient[CHAN_W-1:0];
                        state_ff <= S_WSUM;
                     end
                     2'd2: begin
                        pg_ff    <= div_rsp.quotient[CHAN_W-1:0];
                        state_ff <= S_WSUM;
                     end
                     default: begin
                        pb_ff    <= div_rsp.quotient[CHAN_W-1:0];
                        state_ff <= S_WRITE;
                     end
                  endcase
               end
            end
            S_WRITE: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               step_ff <= '0;
               if (x_ff == bx1_ff[COORD_W-1:0]) begin
                  if (y_ff == by1_ff[COORD_W-1:0]) begin
                     res_ff.written <= count_ff;
                     state_ff       <= S_FINISH;
                  end else begin
                     y_ff        <= y_ff + 1'b1;
                     x_ff        <= bx0_ff[COORD_W-1:0];
                     row_base_ff <= row_base_ff + ADDR_W'(w_eff);
                     state_ff    <= S_EDGE;
                  end
               end else begin
                  x_ff     <= x_ff + 1'b1;
                  state_ff <= S_EDGE;
               end
            end
            S_FINISH: begin
               sweep_cmd_ff <= 1'b0;
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_FINISH) && (!rsp_valid_ff || rsp_chan.ready)) begin
         rsp_valid_ff <= 1'b1;
         rsp_ff       <= res_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.pixel_red      = rsp_ff.red;
   assign rsp_chan.pixel_green    = rsp_ff.green;
   assign rsp_chan.pixel_blue     = rsp_ff.blue;
   assign rsp_chan.pixel_depth    = rsp_ff.depth;
   assign rsp_chan.pixels_written = rsp_ff.written;
   assign rsp_chan.degenerate     = rsp_ff.degen;

   // a store write in a draw always carries a nearer depth than the one read
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |-> (z_ff < stored_depth))
      else $error("depth write without passing the depth test");

   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("divider finished outside the wait state");

   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != S_IDLE))
      else $error("accepted transaction did not start");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EDGE) |-> (x_ff <= bx1_ff[COORD_W-1:0]) && (y_ff <= by1_ff[COORD_W-1:0]))
      else $error("pixel walk left the bounding box");

endmodule
